### rtl/cal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_pkg
// Opcodes, status codes and the control struct shared by the list and its cells.
// ----------------------------------------------------------------------------
package cal_pkg;

   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int KEY_W    = 64;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

   // broadcast to every cell for one cycle when an operation commits
   typedef struct packed {
      logic ins;
      logic rem;
      logic clr;
   } cell_cmd_type;

endpackage
`default_nettype wire

### rtl/cal_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_req_if / cal_rsp_if
// Valid/ready channels for list operations and their results.
// ----------------------------------------------------------------------------
interface cal_req_if;
   logic                           valid;
   logic                           ready;
   logic [cal_pkg::OPCODE_W-1:0]   opcode;
   logic [cal_pkg::KEY_W-1:0]      key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface cal_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cal_pkg::STATUS_W-1:0]   status;
   logic [cal_pkg::COUNT_W-1:0]    count;

   modport source (output valid, output status, output count, input ready);
   modport sink   (input valid, input status, input count, output ready);
endinterface
`default_nettype wire

### rtl/cal_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_cell
// One list slot: holds a key and its occupied flag, compares against the
// broadcast key and pulls its right neighbor's slot in on a remove.
// ----------------------------------------------------------------------------
module cal_cell #(
   parameter int KEY_W = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire cal_pkg::cell_cmd_type cmd,
   input  wire  [KEY_W-1:0]         key,
   input  wire                      prev_valid,
   input  wire                      found_in,
   input  wire  [KEY_W-1:0]         next_entry,
   input  wire                      next_valid,
   output logic                     found_out,
   output logic [KEY_W-1:0]         entry_out,
   output logic                     valid_out
);

   logic [KEY_W-1:0] entry_ff, entry_in;
   logic             valid_ff, valid_in;

   // first match at or left of this cell
   assign found_out = found_in | (valid_ff && (entry_ff == key));
   assign entry_out = entry_ff;
   assign valid_out = valid_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.clr) begin
         valid_in = 1'b0;
      end else if (cmd.ins && !valid_ff && prev_valid) begin
         // first free slot
         entry_in = key;
         valid_in = 1'b1;
      end else if (cmd.rem && found_out) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

### rtl/compacting_array_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_array_list
// Contiguous list of short string keys with insert, remove-and-compact, clear.
// ----------------------------------------------------------------------------
// Each operation runs in two steps: the word is taken and its key normalized
// (cut at the first zero byte, limited to KEY_BYTES bytes), then in the next
// cycle every cell compares its slot with the key in parallel, the first-match
// flag ripples along the row of cells, and insert, compaction or clear is
// applied together with the result. One operation is in flight at a time; a
// finished result sits in an output register while the next word is taken,
// and the execute step waits only if that register is still full. Opcode 3
// is consumed with no result. Count is the occupancy masked to 5 bits.
// ----------------------------------------------------------------------------
module compacting_array_list #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BYTES   = 8
) (
   input  wire        clock,
   input  wire        reset,
   cal_req_if.sink    req_chan,
   cal_rsp_if.source  rsp_chan
);

   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                       state_ff, state_in;
   logic [cal_pkg::OPCODE_W-1:0]    opcode_ff, opcode_in;
   logic [KEY_W-1:0]                key_ff, key_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cal_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [cal_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                            commit;
   logic                            key_empty;
   logic                            full;
   logic                            found_any;
   logic                            rsp_load;
   logic [cal_pkg::STATUS_W-1:0]    status_calc;
   cal_pkg::cell_cmd_type           cmd;

   logic [KEY_W-1:0]                ent   [MAX_ENTRIES+1];
   logic [MAX_ENTRIES:0]            vld;
   logic [MAX_ENTRIES:0]            fnd;

   // ---------------------------------------------------------------- key cut
   always_comb begin
      logic stop;
      stop   = 1'b0;
      key_in = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (req_chan.key[8*b +: 8] == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            key_in[8*b +: 8] = req_chan.key[8*b +: 8];
         end
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign opcode_in      = req_chan.opcode;

   // ---------------------------------------------------------------- cells
   assign ent[MAX_ENTRIES] = '0;
   assign vld[MAX_ENTRIES] = 1'b0;
   assign fnd[0]           = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      cal_cell #(.KEY_W(KEY_W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .key        (key_ff),
         .prev_valid ((i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i-1]),
         .found_in   (fnd[i]),
         .next_entry (ent[i+1]),
         .next_valid (vld[i+1]),
         .found_out  (fnd[i+1]),
         .entry_out  (ent[i]),
         .valid_out  (vld[i])
      );
   end

   assign full      = vld[MAX_ENTRIES-1];
   assign found_any = fnd[MAX_ENTRIES];
   assign key_empty = (key_ff == '0);
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   // ---------------------------------------------------------------- control
   always_comb begin
      cmd         = '0;
      count_in    = count_ff;
      status_calc = cal_pkg::ST_CLEARED;
      rsp_load    = 1'b0;
      case (opcode_ff)
         cal_pkg::OP_INSERT: begin
            rsp_load    = 1'b1;
            status_calc = full ? cal_pkg::ST_FULL : cal_pkg::ST_INSERTED;
            cmd.ins     = commit && !key_empty;
            if (!full && !key_empty) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         cal_pkg::OP_REMOVE: begin
            rsp_load = 1'b1;
            if (key_empty) begin
               // empty key matches the first free slot
               status_calc = full ? cal_pkg::ST_NOT_FOUND : cal_pkg::ST_REMOVED;
            end else begin
               status_calc = found_any ? cal_pkg::ST_REMOVED : cal_pkg::ST_NOT_FOUND;
               cmd.rem     = commit;
               if (found_any) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         cal_pkg::OP_CLEAR: begin
            rsp_load    = 1'b1;
            status_calc = cal_pkg::ST_CLEARED;
            cmd.clr     = commit;
            count_in    = '0;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      if (!commit) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit && rsp_load) begin
         rsp_valid_in = 1'b1;
         status_in    = status_calc;
         rsp_count_in = cal_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         opcode_ff <= opcode_in;
         key_ff    <= key_in;
      end
      status_ff    <= status_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.count  = rsp_count_ff;

   // ---------------------------------------------------------------- checks
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("occupancy above list size");

   a_count_matches_cells : assert property (@(posedge clock) disable iff (reset)
      $countones(vld[MAX_ENTRIES-1:0]) == int'(count_ff))
      else $error("occupied flags disagree with count");

   a_rsp_after_exec : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result appeared without an executing operation");

endmodule
`default_nettype wire

### sim/tb_compacting_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_array_list
// Self-checking bench for the compacting key list. A scoreboard keeps its own
// copy of the slots and the occupancy and predicts status and count for every
// accepted word that has a result. Directed words cover empty keys, keys cut
// at a zero byte, the full list and the unused opcode. Random words follow,
// sent in bursts, while the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_compacting_array_list;
   import cal_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int KEY_BYTES   = 8;
   localparam int WORD_TARGET = 1550;
   localparam int CYCLE_LIMIT = 400000;
   localparam int POOL_SIZE   = 32;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } list_result_type;

   class list_scoreboard;
      logic [KEY_W-1:0] slots [LIST_DEPTH];
      int unsigned      fill;
      list_result_type  pending_results [$];
      int               errors;
      int               results_seen;
      int               full_hits;
      int               remove_hits;

      function new();
         foreach (slots[i]) slots[i] = '0;
         fill         = 0;
         errors       = 0;
         results_seen = 0;
         full_hits    = 0;
         remove_hits  = 0;
      endfunction

      // only the low KEY_BYTES bytes count, and the string stops at its first zero byte
      function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
         logic [KEY_W-1:0] v;
         bit               stop;
         v    = '0;
         stop = 0;
         for (int b = 0; b < KEY_BYTES; b++) begin
            if (raw[8*b +: 8] == 8'h00) stop = 1;
            if (!stop) v[8*b +: 8] = raw[8*b +: 8];
         end
         return v;
      endfunction

      function void note_word(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] raw);
         logic [KEY_W-1:0]    nk;
         logic [STATUS_W-1:0] st;
         int                  hit;
         list_result_type     res;
         nk  = trim_key(raw);
         hit = -1;
         case (op)
            OP_INSERT: begin
               if (fill < LIST_DEPTH) begin
                  if (nk != '0) begin
                     slots[fill] = nk;
                     fill++;
                  end
                  st = ST_INSERTED;
               end else begin
                  st = ST_FULL;
                  full_hits++;
               end
            end
            OP_REMOVE: begin
               if (nk == '0) begin
                  // empty key matches the first free slot, if any
                  st = (fill < LIST_DEPTH) ? ST_REMOVED : ST_NOT_FOUND;
               end else begin
                  for (int i = 0; i < fill; i++)
                     if (hit < 0 && slots[i] == nk) hit = i;
                  if (hit >= 0) begin
                     for (int j = hit; j < LIST_DEPTH - 1; j++) slots[j] = slots[j+1];
                     slots[LIST_DEPTH-1] = '0;
                     fill--;
                     st = ST_REMOVED;
                     remove_hits++;
                  end else begin
                     st = ST_NOT_FOUND;
                  end
               end
            end
            OP_CLEAR: begin
               foreach (slots[i]) slots[i] = '0;
               fill = 0;
               st   = ST_CLEARED;
            end
            default: return;  // unused opcode: consumed silently
         endcase
         res.status = st;
         res.count  = fill[COUNT_W-1:0];
         pending_results.push_back(res);
      endfunction

      task report(string what, logic [7:0] got, logic [7:0] want);
         errors++;
         $display("[%0t] MISMATCH %s: got %0h expected %0h", $time, what, got, want);
      endtask

      task check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
         list_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report("unexpected result, status", {5'd0, status}, 8'h00);
         end else begin
            want = pending_results.pop_front();
            if (status !== want.status) report("status", {5'd0, status}, {5'd0, want.status});
            if (count !== want.count) report("count", {3'd0, count}, {3'd0, want.count});
         end
      endtask
   endclass

   logic clock;
   logic reset;

   cal_req_if req_chan ();
   cal_rsp_if rsp_chan ();

   compacting_array_list #(
      .MAX_ENTRIES (LIST_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   list_scoreboard   sb;
   logic [KEY_W-1:0] name_pool [POOL_SIZE];
   logic [KEY_W-1:0] last_wide;
   int               words_sent;
   int               cycle_count;
   int               stall_mode = 0;
   int               stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watch both handshakes; result ready follows a pattern that changes now and then
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            sb.note_word(req_chan.opcode, req_chan.key);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            sb.check_result(rsp_chan.status, rsp_chan.count);
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 120);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
         2:       rsp_chan.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key);
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.key    <= key;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (op != OP_UNUSED) words_sent++;
   endtask

   task automatic idle_cycles(input int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // pool names hit often so removes find something; wide keys toggle every bit
   function logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      int               r;
      int               len;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         k = name_pool[$urandom_range(0, POOL_SIZE-1)];
         if ($urandom_range(0, 3) == 0) begin
            len = 0;
            while (len < 8 && k[8*len +: 8] != 8'h00) len++;
            // junk past the terminator must not change the key
            for (int b = len + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom_range(0, 255));
         end
      end else if (r < 62) begin
         k = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom} & ~64'hFF;
      end else if (r < 70) begin
         k = last_wide;
      end else begin
         k         = {$urandom, $urandom};
         last_wide = k;
      end
      return k;
   endfunction

   initial begin
      int                  len;
      int                  fill_bias;
      int                  burst;
      int                  r;
      logic [OPCODE_W-1:0] op;

      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.opcode <= OP_INSERT;
      req_chan.key    <= '0;
      words_sent      = 0;
      last_wide       = '1;
      sb              = new;
      foreach (name_pool[i]) begin
         name_pool[i] = '0;
         len          = $urandom_range(1, 8);
         for (int b = 0; b < len; b++) name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_word(OP_INSERT, '0);                      // empty key, list not full
      send_word(OP_REMOVE, '0);                      // empty key matches a free slot
      send_word(OP_REMOVE, 64'h0000_0000_0000_6261); // absent key
      send_word(OP_INSERT, '1);                      // all bytes 0xFF
      send_word(OP_INSERT, 64'hDEAD_BEEF_0000_4241); // "AB" with junk after the zero byte
      send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FF00); // leading zero byte: empty
      send_word(OP_UNUSED, '1);                      // no result expected
      for (int i = 0; i < LIST_DEPTH - 2; i++)
         send_word(OP_INSERT, 64'h0000_0000_0000_4B00 | (8'h41 + i));
      send_word(OP_INSERT, 64'h0000_0000_0000_005A); // list full
      send_word(OP_INSERT, '0);                      // empty key on a full list
      send_word(OP_REMOVE, '0);                      // empty key, no free slot
      send_word(OP_REMOVE, 64'h0000_0000_0000_4241); // same "AB", compacts from slot 1
      send_word(OP_CLEAR, '1);

      // random part: bursts lean toward filling or draining the list
      while (words_sent < WORD_TARGET) begin
         fill_bias = $urandom_range(20, 85);
         burst     = $urandom_range(1, 40);
         for (int n = 0; n < burst; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2)                          op = OP_CLEAR;
            else if (r < 4)                     op = OP_UNUSED;
            else if (r < 4 + fill_bias*96/100)  op = OP_INSERT;
            else                                op = OP_REMOVE;
            send_word(op, pick_key());
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      end
      req_chan.valid <= 1'b0;

      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Summary: %0d words sent, %0d results checked", words_sent, sb.results_seen);
      $display("Summary: list full %0d times, %0d removes found their key",
               sb.full_hits, sb.remove_hits);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
rtl/cal_pkg.sv
rtl/cal_if.sv
rtl/cal_cell.sv
rtl/compacting_array_list.sv
sim/tb_compacting_array_list.sv
